@@ src/relation_closure_engine_assert.svh @@
// Assertion macros for the relation closure engine.
// Included by the top level; no other dependencies.
`ifndef RELATION_CLOSURE_ENGINE_ASSERT_SVH
`define RELATION_CLOSURE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define RCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rce: same-cycle check failed");
`define RCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rce: next-cycle check failed");
`else
`define RCE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RCE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/rce_pkg.sv @@
// Shared constants, codes and types of the relation closure engine.
// No dependencies.
package rce_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int ROWS         = 16;
    localparam int ROW_W        = 16;
    localparam int IDX_W        = 4;
    localparam int SIZE_W       = 5;
    localparam int SIZE_LIMIT   = (MAX_ELEMENTS < ROWS) ? MAX_ELEMENTS : ROWS;

    localparam logic [1:0] MODE_REFLEXIVE  = 2'd0;
    localparam logic [1:0] MODE_SYMMETRIC  = 2'd1;
    localparam logic [1:0] MODE_TRANSITIVE = 2'd2;

    localparam logic CFG_IDX_MODE = 1'b0;
    localparam logic CFG_IDX_SIZE = 1'b1;

    // what the row unit does with the row read for an issued access
    localparam logic [2:0] TAG_LOAD   = 3'd0;
    localparam logic [2:0] TAG_PIVOT  = 3'd1;
    localparam logic [2:0] TAG_UPDATE = 3'd2;
    localparam logic [2:0] TAG_BASE   = 3'd3;
    localparam logic [2:0] TAG_GATHER = 3'd4;
    localparam logic [2:0] TAG_EMIT   = 3'd5;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] nm1;
        logic [ROW_W-1:0] colmask;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       tag;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             keep;
    } issue_t;

endpackage

@@ src/rce_matrix_mem.sv @@
// Row store of the adjacency matrix: one write port, one registered read port,
// write-through on a same-row collision, per-row valid bits. Uses rce_pkg.
module rce_matrix_mem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        re,
    input  logic [rce_pkg::IDX_W-1:0]   raddr,
    input  logic                        we,
    input  logic [rce_pkg::IDX_W-1:0]   waddr,
    input  logic [rce_pkg::ROW_W-1:0]   wdata,
    input  logic                        clr,
    output logic [rce_pkg::ROW_W-1:0]   rdata
);

    logic [rce_pkg::ROW_W-1:0] matrix_mem [rce_pkg::ROWS];
    logic [rce_pkg::ROWS-1:0]  vld_reg;
    logic [rce_pkg::ROW_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            matrix_mem[waddr] <= wdata;
        end
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else if (vld_reg[raddr]) begin
                rdata_reg <= matrix_mem[raddr];
            end else begin
                rdata_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/rce_sequencer.sv @@
// Access sequencer: pair loading, Warshall and transpose sweeps, row emission
// and the store clear. Uses rce_pkg.
module rce_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rce_pkg::cfg_t               cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rce_pkg::IDX_W-1:0]   s_from_index,
    input  logic [rce_pkg::IDX_W-1:0]   s_to_index,
    input  logic                        s_last_pair,
    input  logic                        adv,
    input  logic                        s1_busy,
    output rce_pkg::issue_t             issue,
    output logic                        clr
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_TRANS = 3'd2;
    localparam logic [2:0] ST_SYMM  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]                st_reg, st_next;
    logic [rce_pkg::IDX_W-1:0] k_reg, k_next;
    logic [rce_pkg::IDX_W-1:0] i_reg, i_next;
    logic                      head_reg, head_next;

    always_comb begin
        issue     = '0;
        s_ready   = (st_reg == ST_LOAD);
        clr       = 1'b0;
        st_next   = st_reg;
        k_next    = k_reg;
        i_next    = i_reg;
        head_next = head_reg;
        case (st_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    issue.valid = 1'b1;
                    issue.tag   = rce_pkg::TAG_LOAD;
                    issue.row   = s_from_index;
                    issue.col   = s_to_index;
                    issue.keep  = (s_from_index <= cfg.nm1) && (s_to_index <= cfg.nm1);
                    if (s_last_pair) begin
                        st_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                k_next    = '0;
                i_next    = '0;
                head_next = 1'b1;
                case (cfg.mode)
                    rce_pkg::MODE_TRANSITIVE: st_next = ST_TRANS;
                    rce_pkg::MODE_SYMMETRIC:  st_next = ST_SYMM;
                    default:                  st_next = ST_EMIT;
                endcase
            end
            ST_TRANS: begin
                if (adv) begin
                    issue.valid = 1'b1;
                    issue.col   = k_reg;
                    if (head_reg) begin
                        issue.tag = rce_pkg::TAG_PIVOT;
                        issue.row = k_reg;
                        head_next = 1'b0;
                        i_next    = '0;
                    end else begin
                        issue.tag = rce_pkg::TAG_UPDATE;
                        issue.row = i_reg;
                        if (i_reg == cfg.nm1) begin
                            head_next = 1'b1;
                            i_next    = '0;
                            if (k_reg == cfg.nm1) begin
                                st_next = ST_EMIT;
                            end else begin
                                k_next = k_reg + 1'b1;
                            end
                        end else begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                end
            end
            ST_SYMM: begin
                if (adv) begin
                    issue.valid = 1'b1;
                    issue.col   = k_reg;
                    if (head_reg) begin
                        issue.tag = rce_pkg::TAG_BASE;
                        issue.row = k_reg;
                        head_next = 1'b0;
                        i_next    = '0;
                    end else begin
                        issue.tag = rce_pkg::TAG_GATHER;
                        issue.row = i_reg;
                        if (i_reg == cfg.nm1) begin
                            head_next = 1'b1;
                            if (k_reg == cfg.nm1) begin
                                st_next = ST_DONE;
                            end else begin
                                k_next = k_reg + 1'b1;
                            end
                        end else begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (adv) begin
                    issue.valid = 1'b1;
                    issue.tag   = rce_pkg::TAG_EMIT;
                    issue.row   = i_reg;
                    if (i_reg == cfg.nm1) begin
                        st_next = ST_DONE;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!s1_busy) begin
                    clr     = 1'b1;
                    st_next = ST_LOAD;
                end
            end
            default: begin
                st_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_LOAD;
            k_reg    <= '0;
            i_reg    <= '0;
            head_reg <= 1'b1;
        end else begin
            st_reg   <= st_next;
            k_reg    <= k_next;
            i_reg    <= i_next;
            head_reg <= head_next;
        end
    end

endmodule

@@ src/rce_row_unit.sv @@
// Row datapath: takes each row read from the store, writes back merged rows
// and holds the result register. Uses rce_pkg.
module rce_row_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rce_pkg::cfg_t               cfg,
    input  rce_pkg::issue_t             issue,
    input  logic [rce_pkg::ROW_W-1:0]   rdata,
    output logic                        mem_we,
    output logic [rce_pkg::IDX_W-1:0]   mem_waddr,
    output logic [rce_pkg::ROW_W-1:0]   mem_wdata,
    output logic                        adv,
    output logic                        s1_busy,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rce_pkg::IDX_W-1:0]   m_row_number,
    output logic [rce_pkg::ROW_W-1:0]   m_row_bits,
    output logic                        m_last_row
);

    logic                      s1_valid_reg;
    logic [2:0]                s1_tag_reg;
    logic [rce_pkg::IDX_W-1:0] s1_row_reg;
    logic [rce_pkg::IDX_W-1:0] s1_col_reg;
    logic                      s1_keep_reg;
    logic [rce_pkg::ROW_W-1:0] pivot_reg, pivot_next;
    logic [rce_pkg::ROW_W-1:0] acc_reg, acc_next;
    logic                      out_valid_reg;
    logic [rce_pkg::IDX_W-1:0] out_row_reg;
    logic [rce_pkg::ROW_W-1:0] out_bits_reg;
    logic                      out_last_reg;

    logic                      s1_go;
    logic                      consume;
    logic                      emit;
    logic [rce_pkg::IDX_W-1:0] emit_row;
    logic [rce_pkg::ROW_W-1:0] emit_bits;

    assign adv     = !out_valid_reg || m_ready;
    assign s1_go   = !s1_valid_reg || (s1_tag_reg == rce_pkg::TAG_LOAD) || adv;
    assign consume = s1_valid_reg && s1_go;
    assign s1_busy = s1_valid_reg;

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = s1_row_reg;
        mem_wdata  = rdata | pivot_reg;
        pivot_next = pivot_reg;
        acc_next   = acc_reg;
        emit       = 1'b0;
        emit_row   = s1_row_reg;
        emit_bits  = rdata;
        if (consume) begin
            case (s1_tag_reg)
                rce_pkg::TAG_LOAD: begin
                    mem_we    = s1_keep_reg;
                    mem_wdata = rdata | (rce_pkg::ROW_W'(1) << s1_col_reg);
                end
                rce_pkg::TAG_PIVOT: begin
                    pivot_next = rdata;
                end
                rce_pkg::TAG_UPDATE: begin
                    mem_we = rdata[s1_col_reg];
                end
                rce_pkg::TAG_BASE: begin
                    acc_next = rdata;
                end
                rce_pkg::TAG_GATHER: begin
                    acc_next = acc_reg
                        | (rce_pkg::ROW_W'(rdata[s1_col_reg]) << s1_row_reg);
                    if (s1_row_reg == cfg.nm1) begin
                        emit      = 1'b1;
                        emit_row  = s1_col_reg;
                        emit_bits = acc_next;
                    end
                end
                rce_pkg::TAG_EMIT: begin
                    emit = 1'b1;
                    if (cfg.mode == rce_pkg::MODE_REFLEXIVE) begin
                        emit_bits = rdata | (rce_pkg::ROW_W'(1) << s1_row_reg);
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_go) begin
                s1_valid_reg <= issue.valid;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            s1_tag_reg  <= issue.tag;
            s1_row_reg  <= issue.row;
            s1_col_reg  <= issue.col;
            s1_keep_reg <= issue.keep;
        end
        pivot_reg <= pivot_next;
        acc_reg   <= acc_next;
        if (emit) begin
            out_row_reg  <= emit_row;
            out_bits_reg <= emit_bits & cfg.colmask;
            out_last_reg <= (emit_row == cfg.nm1);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_row_number = out_row_reg;
    assign m_row_bits   = out_bits_reg;
    assign m_last_row   = out_last_reg;

endmodule

@@ src/relation_closure_engine.sv @@
// Top level of the relation closure engine: configuration registers, size
// decode, sequencer, row store and row datapath. Uses rce_pkg and the assert header.
//
// Pairs are taken one per cycle and set one bit of a 16 x 16 row store through a
// read-modify-write on its single read port. The pair marked last closes the
// relation: input stalls through a drain state, then the transitive mode runs
// Warshall sweeps followed by row emission, the symmetric mode emits each row as
// it gathers its column from all rows, and the reflexive mode and the unused mode
// emit the rows directly; the last row then retires from the datapath and the
// store is cleared before the next pair is taken. Sweeps and emission read one
// row per cycle and pause while the result is not taken.
`include "relation_closure_engine_assert.svh"

module relation_closure_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [rce_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rce_pkg::IDX_W-1:0]     s_from_index,
    input  logic [rce_pkg::IDX_W-1:0]     s_to_index,
    input  logic                          s_last_pair,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rce_pkg::IDX_W-1:0]     m_row_number,
    output logic [rce_pkg::ROW_W-1:0]     m_row_bits,
    output logic                          m_last_row
);

    logic [1:0]                 mode_reg;
    logic [rce_pkg::SIZE_W-1:0] size_reg;
    logic [rce_pkg::SIZE_W-1:0] n_eff;
    rce_pkg::cfg_t              cfg;
    rce_pkg::issue_t            issue;
    logic                       adv;
    logic                       s1_busy;
    logic                       clr;
    logic                       mem_we;
    logic [rce_pkg::IDX_W-1:0]  mem_waddr;
    logic [rce_pkg::ROW_W-1:0]  mem_wdata;
    logic [rce_pkg::ROW_W-1:0]  mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= rce_pkg::MODE_TRANSITIVE;
            size_reg <= rce_pkg::SIZE_W'(rce_pkg::SIZE_LIMIT);
        end else if (cfg_valid) begin
            case (cfg_index)
                rce_pkg::CFG_IDX_MODE: mode_reg <= cfg_data[1:0];
                rce_pkg::CFG_IDX_SIZE: size_reg <= cfg_data;
                default:               mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb begin
        if (size_reg == '0) begin
            n_eff = rce_pkg::SIZE_W'(1);
        end else if (size_reg > rce_pkg::SIZE_W'(rce_pkg::SIZE_LIMIT)) begin
            n_eff = rce_pkg::SIZE_W'(rce_pkg::SIZE_LIMIT);
        end else begin
            n_eff = size_reg;
        end
        cfg.mode = mode_reg;
        cfg.nm1  = rce_pkg::IDX_W'(n_eff - 1'b1);
        if (n_eff >= rce_pkg::SIZE_W'(rce_pkg::ROW_W)) begin
            cfg.colmask = '1;
        end else begin
            cfg.colmask = rce_pkg::ROW_W'(((rce_pkg::ROW_W+1)'(1) << n_eff) - 1'b1);
        end
    end

    rce_sequencer u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_from_index (s_from_index),
        .s_to_index   (s_to_index),
        .s_last_pair  (s_last_pair),
        .adv          (adv),
        .s1_busy      (s1_busy),
        .issue        (issue),
        .clr          (clr)
    );

    rce_matrix_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (issue.valid),
        .raddr   (issue.row),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .clr     (clr),
        .rdata   (mem_rdata)
    );

    rce_row_unit u_row (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .issue        (issue),
        .rdata        (mem_rdata),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .adv          (adv),
        .s1_busy      (s1_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_number (m_row_number),
        .m_row_bits   (m_row_bits),
        .m_last_row   (m_last_row)
    );

    `RCE_ASSERT_IMP(a_no_write_on_clear, aclk, aresetn, mem_we, !clr)
    `RCE_ASSERT_NXT(a_last_pair_stalls, aclk, aresetn, s_valid && s_ready && s_last_pair, !s_ready)
    `RCE_ASSERT_NXT(a_clear_reopens, aclk, aresetn, clr, s_ready && !s1_busy)
    `RCE_ASSERT_IMP(a_load_never_stalls, aclk, aresetn, s_ready,
        adv || !s1_busy || !issue.valid || issue.tag == rce_pkg::TAG_LOAD)

endmodule

@@ verif/testbench.sv @@
// Testbench for relation_closure_engine: directed and random relations, random idling.
// Predicts the emitted rows from an internal matrix model; depends on rce_pkg.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PAIRS = 480;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES = 300;

    typedef struct packed {
        logic [rce_pkg::IDX_W-1:0] row;
        logic [rce_pkg::ROW_W-1:0] bits;
        logic                      last;
    } matrix_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic                         cfg_index;
    logic [rce_pkg::SIZE_W-1:0]   cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [rce_pkg::IDX_W-1:0]    s_from_index;
    logic [rce_pkg::IDX_W-1:0]    s_to_index;
    logic                         s_last_pair;
    logic                         m_valid;
    logic                         m_ready;
    logic [rce_pkg::IDX_W-1:0]    m_row_number;
    logic [rce_pkg::ROW_W-1:0]    m_row_bits;
    logic                         m_last_row;

    logic [rce_pkg::ROW_W-1:0]    rel_rows [rce_pkg::ROWS];
    logic [1:0]                   mode_q;
    logic [rce_pkg::SIZE_W-1:0]   size_q;
    matrix_row_t                  pending_rows [$];

    int                  cycle_count;
    int                  pairs_sent;
    int                  relations_closed;
    int                  rows_checked;
    int                  cfg_writes;
    int                  mismatches;
    int                  rx_hold;
    bit                  no_idle;

    relation_closure_engine dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_from_index (s_from_index),
        .s_to_index   (s_to_index),
        .s_last_pair  (s_last_pair),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_number (m_row_number),
        .m_row_bits   (m_row_bits),
        .m_last_row   (m_last_row)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int elem_count();
        if (size_q == 0) return 1;
        if (size_q > rce_pkg::SIZE_LIMIT) return rce_pkg::SIZE_LIMIT;
        return int'(size_q);
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mark one pair; on the last pair form the closure and queue the rows
    function automatic void record_pair(logic [rce_pkg::IDX_W-1:0] f,
                                        logic [rce_pkg::IDX_W-1:0] t, logic l);
        int n;
        logic [rce_pkg::ROW_W-1:0] mask;
        logic [rce_pkg::ROW_W-1:0] sym [rce_pkg::ROWS];
        matrix_row_t r;
        n = elem_count();
        if (f < n && t < n) rel_rows[f][t] = 1'b1;
        if (!l) return;
        mask = (n >= rce_pkg::ROW_W) ? '1 : rce_pkg::ROW_W'((32'd1 << n) - 1);
        for (int i = 0; i < rce_pkg::ROWS; i++)
            rel_rows[i] = (i < n) ? (rel_rows[i] & mask) : '0;
        case (mode_q)
            rce_pkg::MODE_REFLEXIVE: begin
                for (int i = 0; i < n; i++) rel_rows[i][i] = 1'b1;
            end
            rce_pkg::MODE_SYMMETRIC: begin
                for (int i = 0; i < n; i++) begin
                    sym[i] = rel_rows[i];
                    for (int j = 0; j < n; j++)
                        if (rel_rows[j][i]) sym[i][j] = 1'b1;
                end
                for (int i = 0; i < n; i++) rel_rows[i] = sym[i];
            end
            rce_pkg::MODE_TRANSITIVE: begin
                for (int k = 0; k < n; k++)
                    for (int i = 0; i < n; i++)
                        if (rel_rows[i][k]) rel_rows[i] = rel_rows[i] | rel_rows[k];
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            r.row  = rce_pkg::IDX_W'(i);
            r.bits = rel_rows[i];
            r.last = (i == n - 1);
            pending_rows.push_back(r);
        end
        for (int i = 0; i < rce_pkg::ROWS; i++) rel_rows[i] = '0;
        relations_closed++;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            record_pair(s_from_index, s_to_index, s_last_pair);
    end

    always @(posedge aclk) begin
        matrix_row_t exp_row;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected row %0d bits %h last %b", $time,
                         m_row_number, m_row_bits, m_last_row);
                mismatches++;
            end else begin
                exp_row = pending_rows.pop_front();
                rows_checked++;
                if (m_row_number !== exp_row.row) begin
                    $display("%0t: row_number expected %0d actual %0d", $time,
                             exp_row.row, m_row_number);
                    mismatches++;
                end
                if (m_row_bits !== exp_row.bits) begin
                    $display("%0t: row %0d row_bits expected %h actual %h", $time,
                             exp_row.row, exp_row.bits, m_row_bits);
                    mismatches++;
                end
                if (m_last_row !== exp_row.last) begin
                    $display("%0t: row %0d last_row expected %b actual %b", $time,
                             exp_row.row, exp_row.last, m_last_row);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d rows outstanding", $time, pending_rows.size());
            $display("tb: failure");
            $finish;
        end
    end

    // result side: long hold-off when requested, otherwise random stalls
    initial begin : receiver
        int stall;
        stall = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 25) stall = gap_length();
            end
        end
    end

    task automatic send_pair(input logic [rce_pkg::IDX_W-1:0] f,
                             input logic [rce_pkg::IDX_W-1:0] t,
                             input logic l);
        int gap;
        gap = no_idle ? 0 : gap_length();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_from_index <= f;
        s_to_index   <= t;
        s_last_pair  <= l;
        do @(posedge aclk); while (!s_ready);
        pairs_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [rce_pkg::SIZE_W-1:0] data);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == rce_pkg::CFG_IDX_MODE) mode_q = data[1:0];
        else size_q = data;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_defaults();
        send_pair(4'd0, 4'd1, 1'b0);
        send_pair(4'd1, 4'd2, 1'b0);
        send_pair(4'd2, 4'd15, 1'b0);
        send_pair(4'd15, 4'd15, 1'b0);
        send_pair(4'd15, 4'd0, 1'b1);
    endtask

    task automatic test_reflexive();
        write_reg(rce_pkg::CFG_IDX_MODE, 5'(rce_pkg::MODE_REFLEXIVE));
        send_pair(4'd0, 4'd15, 1'b0);
        send_pair(4'd15, 4'd0, 1'b1);
    endtask

    task automatic test_symmetric();
        write_reg(rce_pkg::CFG_IDX_MODE, 5'(rce_pkg::MODE_SYMMETRIC));
        send_pair(4'd3, 4'd7, 1'b0);
        send_pair(4'd15, 4'd0, 1'b1);
    endtask

    task automatic test_unused_mode();
        write_reg(rce_pkg::CFG_IDX_MODE, 5'd31);
        send_pair(4'd5, 4'd9, 1'b1);
    endtask

    task automatic test_out_of_range();
        write_reg(rce_pkg::CFG_IDX_MODE, 5'(rce_pkg::MODE_TRANSITIVE));
        write_reg(rce_pkg::CFG_IDX_SIZE, 5'd4);
        send_pair(4'd4, 4'd0, 1'b0);
        send_pair(4'd0, 4'd4, 1'b0);
        send_pair(4'd15, 4'd15, 1'b0);
        send_pair(4'd0, 4'd1, 1'b0);
        send_pair(4'd1, 4'd3, 1'b1);
        // ignored pair that still closes the relation
        send_pair(4'd9, 4'd9, 1'b1);
    endtask

    task automatic test_size_limits();
        write_reg(rce_pkg::CFG_IDX_MODE, 5'(rce_pkg::MODE_REFLEXIVE));
        write_reg(rce_pkg::CFG_IDX_SIZE, 5'd0);
        send_pair(4'd1, 4'd0, 1'b1);
        write_reg(rce_pkg::CFG_IDX_SIZE, 5'd31);
        send_pair(4'd15, 4'd14, 1'b1);
        write_reg(rce_pkg::CFG_IDX_MODE, 5'(rce_pkg::MODE_SYMMETRIC));
        write_reg(rce_pkg::CFG_IDX_SIZE, 5'd17);
        send_pair(4'd0, 4'd15, 1'b1);
    endtask

    task automatic test_size_change_mid_relation();
        write_reg(rce_pkg::CFG_IDX_MODE, 5'(rce_pkg::MODE_TRANSITIVE));
        write_reg(rce_pkg::CFG_IDX_SIZE, 5'd16);
        send_pair(4'd10, 4'd3, 1'b0);
        send_pair(4'd2, 4'd12, 1'b0);
        send_pair(4'd1, 4'd2, 1'b0);
        write_reg(rce_pkg::CFG_IDX_SIZE, 5'd8);
        send_pair(4'd0, 4'd1, 1'b1);
    endtask

    // receiver holds off while full-size relations keep coming
    task automatic test_backpressure();
        write_reg(rce_pkg::CFG_IDX_SIZE, 5'd16);
        no_idle = 1'b1;
        rx_hold = 400;
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 6; k++)
                send_pair(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), k == 5);
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int n;
        int len;
        int r;
        bit broken;
        logic [rce_pkg::IDX_W-1:0] f;
        logic [rce_pkg::IDX_W-1:0] t;
        while (pairs_sent < RANDOM_PAIRS) begin
            if ($urandom_range(0, 99) < 35) begin
                if ($urandom_range(0, 99) < 70)
                    write_reg(rce_pkg::CFG_IDX_MODE, 5'($urandom_range(0, 2)));
                else
                    write_reg(rce_pkg::CFG_IDX_MODE, 5'($urandom_range(0, 31)));
            end
            if ($urandom_range(0, 99) < 40) begin
                r = $urandom_range(0, 99);
                if (r < 60) write_reg(rce_pkg::CFG_IDX_SIZE, 5'($urandom_range(1, 6)));
                else if (r < 85) write_reg(rce_pkg::CFG_IDX_SIZE, 5'($urandom_range(7, 15)));
                else if (r < 90) write_reg(rce_pkg::CFG_IDX_SIZE, 5'd16);
                else write_reg(rce_pkg::CFG_IDX_SIZE, 5'($urandom_range(0, 31)));
            end
            no_idle = ($urandom_range(0, 99) < 15);
            n = elem_count();
            len = $urandom_range(1, (n < 4) ? 4 : 12);
            broken = ($urandom_range(0, 99) < 8);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 85) begin
                    f = rce_pkg::IDX_W'($urandom_range(0, n - 1));
                    t = rce_pkg::IDX_W'($urandom_range(0, n - 1));
                end else begin
                    f = rce_pkg::IDX_W'($urandom_range(0, 15));
                    t = rce_pkg::IDX_W'($urandom_range(0, 15));
                end
                send_pair(f, t, (k == len - 1) && !broken);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = rce_pkg::CFG_IDX_MODE;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_from_index = '0;
        s_to_index   = '0;
        s_last_pair  = 1'b0;
        mode_q       = rce_pkg::MODE_TRANSITIVE;
        size_q       = 5'd16;
        rx_hold      = 0;
        no_idle      = 1'b0;
        for (int i = 0; i < rce_pkg::ROWS; i++) rel_rows[i] = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_defaults();
        test_reflexive();
        test_symmetric();
        test_unused_mode();
        test_out_of_range();
        test_size_limits();
        test_size_change_mid_relation();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_rows.size() != 0) begin
            $display("%0t: %0d expected rows never arrived", $time, pending_rows.size());
            mismatches++;
        end
        $display("covered %0d pairs, %0d closed relations, %0d rows compared, %0d reg writes",
                 pairs_sent, relations_closed, rows_checked, cfg_writes);
        $display("mismatches: %0d after %0d cycles", mismatches, cycle_count);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
